// ===== rtl/core/sdtq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted deadline timer queue.
// Sizes, request/result codes, cell entry and cell control types. No dependencies.
package sdtq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 4;
  localparam int KIND_W     = 2;
  localparam int RKIND_W    = 3;

  localparam logic [ID_W-1:0] NO_TIMER = '0;

  typedef enum logic [KIND_W-1:0] {
    REQ_SET    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_EXPIRE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_kind_t;

  typedef enum logic [RKIND_W-1:0] {
    RES_SET_DONE    = 3'd0,
    RES_CANCEL_DONE = 3'd1,
    RES_EXPIRED     = 3'd2,
    RES_EXPIRY_DONE = 3'd3,
    RES_REMAINING   = 3'd4
  } res_kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_REMOVE_ID   = 2'd1,
    CELL_REMOVE_HEAD = 2'd2,
    CELL_INSERT      = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   timer;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sdtq_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces of the timer queue.
// Depends on sdtq_pkg for field widths.
interface sdtq_in_if;
  logic                         valid;
  logic                         ready;
  logic [sdtq_pkg::KIND_W-1:0]  kind;
  logic [sdtq_pkg::ID_W-1:0]    timer_id;
  logic [sdtq_pkg::TIME_W-1:0]  delay_ticks;
  logic [sdtq_pkg::TIME_W-1:0]  now;

  modport source (output valid, kind, timer_id, delay_ticks, now, input ready);
  modport sink   (input valid, kind, timer_id, delay_ticks, now, output ready);
endinterface

interface sdtq_out_if;
  logic                         valid;
  logic                         ready;
  logic [sdtq_pkg::RKIND_W-1:0] result_kind;
  logic [sdtq_pkg::ID_W-1:0]    result_timer;
  logic [sdtq_pkg::TIME_W-1:0]  result_value;
  logic                         alarm_valid;
  logic [sdtq_pkg::TIME_W-1:0]  alarm_time;
  logic                         last;

  modport source (output valid, result_kind, result_timer, result_value, alarm_valid,
                  alarm_time, last, input ready);
  modport sink   (input valid, result_kind, result_timer, result_value, alarm_valid,
                  alarm_time, last, output ready);
endinterface

// ===== rtl/core/sdtq_cell.sv =====
`timescale 1ns / 1ps
// One queue cell: holds one timer entry, shifts left on removal, right on insert.
// Depends on sdtq_pkg.
module sdtq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sdtq_pkg::cell_ctrl_t ctrl,
  input  sdtq_pkg::entry_t    left_entry,
  input  sdtq_pkg::entry_t    right_entry,
  input  logic                keep_in,
  input  logic                match_in,
  output logic                keep_out,
  output logic                match_out,
  output logic                hit,
  output sdtq_pkg::entry_t    entry
);

  sdtq_pkg::entry_t entry_r;
  sdtq_pkg::entry_t entry_nxt;
  logic             keep;
  logic             shift;

  always_comb begin
    hit   = entry_r.valid && (entry_r.timer == ctrl.id);
    keep  = entry_r.valid && (entry_r.deadline < ctrl.key);
    shift = match_in || ((ctrl.op == sdtq_pkg::CELL_REMOVE_ID) && hit);
    entry_nxt = entry_r;
    case (ctrl.op) inside
      sdtq_pkg::CELL_REMOVE_ID, sdtq_pkg::CELL_REMOVE_HEAD: begin
        if (shift) entry_nxt = right_entry;
      end
      sdtq_pkg::CELL_INSERT: begin
        if (!keep) begin
          if (keep_in) begin
            entry_nxt.valid    = 1'b1;
            entry_nxt.deadline = ctrl.key;
            entry_nxt.timer    = ctrl.id;
          end else begin
            entry_nxt = left_entry;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign keep_out  = keep;
  assign match_out = shift;
  assign entry     = entry_r;

endmodule

// ===== rtl/core/sdtq_chain.sv =====
`timescale 1ns / 1ps
// Row of queue cells with neighbor links, head view and timer lookup.
// Depends on sdtq_pkg and sdtq_cell.
module sdtq_chain (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sdtq_pkg::cell_ctrl_t                ctrl,
  output sdtq_pkg::entry_t                    head,
  output logic [sdtq_pkg::NUM_TIMERS-1:0]     valid_vec,
  output logic [sdtq_pkg::NUM_TIMERS-1:0]     hit_vec,
  output logic                                found,
  output logic [sdtq_pkg::TIME_W-1:0]         found_deadline
);

  localparam int N = sdtq_pkg::NUM_TIMERS;

  sdtq_pkg::entry_t ents [N];
  logic [N-1:0]     keep_c;
  logic [N-1:0]     match_c;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      sdtq_pkg::entry_t left_e;
      sdtq_pkg::entry_t right_e;
      logic             keep_i;
      logic             match_i;
      if (g == 0) begin : g_first
        assign left_e  = '0;
        assign keep_i  = 1'b1;
        assign match_i = (ctrl.op == sdtq_pkg::CELL_REMOVE_HEAD);
      end else begin : g_mid
        assign left_e  = ents[g-1];
        assign keep_i  = keep_c[g-1];
        assign match_i = match_c[g-1];
      end
      if (g == N-1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = ents[g+1];
      end
      sdtq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .left_entry  (left_e),
        .right_entry (right_e),
        .keep_in     (keep_i),
        .match_in    (match_i),
        .keep_out    (keep_c[g]),
        .match_out   (match_c[g]),
        .hit         (hit_vec[g]),
        .entry       (ents[g])
      );
      assign valid_vec[g] = ents[g].valid;
    end
  endgenerate

  assign head  = ents[0];
  assign found = |hit_vec;

  always_comb begin
    found_deadline = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_vec[i]) found_deadline = found_deadline | ents[i].deadline;
    end
  end

endmodule

// ===== rtl/core/sorted_deadline_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sorted deadline timer queue: request sequencer and result register.
// Depends on sdtq_pkg, sdtq_if and sdtq_chain.
//
//   channel   dir  transfer when         payload
//   in_chan   in   valid && ready        kind, timer_id, delay_ticks, now
//   out_chan  out  valid && ready        result_kind, result_timer, result_value,
//                                        alarm_valid, alarm_time, last
//
// Cancel makes a remove pass; set makes a remove pass, then an insert pass through
// the cell row; expire removes the head entry once per expired timer.
// Reset clears the cell valid bits; no clearing pass.
// A stalled result holds the sequencer; a new request is taken while the last
// result of the previous one still waits in the output register.
module sorted_deadline_timer_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  sdtq_in_if.sink     in_chan,
  sdtq_out_if.source  out_chan
);

  localparam int TW = sdtq_pkg::TIME_W;
  localparam int IW = sdtq_pkg::ID_W;
  localparam int N  = sdtq_pkg::NUM_TIMERS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_INS  = 5'b00100,
    S_EXP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  sdtq_pkg::req_kind_t  kind_r;
  logic [IW-1:0]        id_r;
  logic [TW-1:0]        now_r;
  logic [TW-1:0]        dl_r;
  logic                 in_range_r;
  logic                 prev_valid_r;
  logic [TW-1:0]        prev_d_r;
  logic                 found_r;
  logic [TW-1:0]        sel_d_r;

  logic                 out_valid_r;
  sdtq_pkg::res_kind_t  out_kind_r;
  logic [IW-1:0]        out_timer_r;
  logic [TW-1:0]        out_value_r;
  logic                 out_av_r;
  logic [TW-1:0]        out_at_r;
  logic                 out_last_r;

  sdtq_pkg::cell_ctrl_t ctrl;
  sdtq_pkg::entry_t     head;
  logic [N-1:0]         valid_vec;
  logic [N-1:0]         hit_vec;
  logic                 found;
  logic [TW-1:0]        found_deadline;

  logic                 accept;
  logic                 out_free;
  logic                 head_due;
  logic [TW-1:0]        head_time;
  logic                 load_exp;
  logic                 load_fin;
  sdtq_pkg::res_kind_t  fin_kind;
  logic [IW-1:0]        fin_timer;
  logic [TW-1:0]        fin_value;
  logic                 fin_av;

  sdtq_chain u_chain (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .head           (head),
    .valid_vec      (valid_vec),
    .hit_vec        (hit_vec),
    .found          (found),
    .found_deadline (found_deadline)
  );

  assign in_chan.ready = rst_n && (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign head_due      = head.valid && (head.deadline <= now_r);
  assign head_time     = head.valid ? head.deadline : '0;
  assign load_exp      = (state_r == S_EXP) && out_free && head_due;
  assign load_fin      = (state_r == S_DONE) && out_free;

  always_comb begin
    ctrl.id  = id_r;
    ctrl.key = dl_r;
    ctrl.op  = sdtq_pkg::CELL_HOLD;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (in_range_r && (kind_r == sdtq_pkg::REQ_SET || kind_r == sdtq_pkg::REQ_CANCEL)) begin
          ctrl.op = sdtq_pkg::CELL_REMOVE_ID;
        end
        if (kind_r == sdtq_pkg::REQ_EXPIRE) begin
          state_nxt = S_EXP;
        end else if (kind_r == sdtq_pkg::REQ_SET && in_range_r) begin
          state_nxt = S_INS;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS: begin
        ctrl.op   = sdtq_pkg::CELL_INSERT;
        state_nxt = S_DONE;
      end
      S_EXP: begin
        if (out_free) begin
          if (head_due) begin
            ctrl.op = sdtq_pkg::CELL_REMOVE_HEAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fin_kind  = sdtq_pkg::RES_SET_DONE;
    fin_timer = id_r;
    fin_value = '0;
    fin_av    = 1'b0;
    unique case (kind_r)
      sdtq_pkg::REQ_SET: begin
        fin_av = in_range_r && (!prev_valid_r || (prev_d_r != head.deadline));
      end
      sdtq_pkg::REQ_CANCEL: begin
        fin_kind  = sdtq_pkg::RES_CANCEL_DONE;
        fin_value = TW'(found_r);
      end
      sdtq_pkg::REQ_EXPIRE: begin
        fin_kind  = sdtq_pkg::RES_EXPIRY_DONE;
        fin_timer = sdtq_pkg::NO_TIMER;
        fin_av    = head.valid;
      end
      sdtq_pkg::REQ_QUERY: begin
        fin_kind = sdtq_pkg::RES_REMAINING;
        if (found_r && (sel_d_r > now_r)) fin_value = sel_d_r - now_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= sdtq_pkg::req_kind_t'(in_chan.kind);
      id_r         <= in_chan.timer_id;
      now_r        <= in_chan.now;
      dl_r         <= in_chan.now + in_chan.delay_ticks;
      in_range_r   <= (32'(in_chan.timer_id) < 32'(N));
      prev_valid_r <= head.valid;
      prev_d_r     <= head.deadline;
    end
    if (state_r == S_EXEC) begin
      found_r <= found && in_range_r;
      sel_d_r <= found_deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready) out_valid_r <= 1'b0;
      if (load_exp || load_fin) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exp) begin
      out_kind_r  <= sdtq_pkg::RES_EXPIRED;
      out_timer_r <= head.timer;
      out_value_r <= '0;
      out_av_r    <= 1'b0;
      out_at_r    <= '0;
      out_last_r  <= 1'b0;
    end else if (load_fin) begin
      out_kind_r  <= fin_kind;
      out_timer_r <= fin_timer;
      out_value_r <= fin_value;
      out_av_r    <= fin_av;
      out_at_r    <= head_time;
      out_last_r  <= 1'b1;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_kind_r;
  assign out_chan.result_timer = out_timer_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.alarm_valid  = out_av_r;
  assign out_chan.alarm_time   = out_at_r;
  assign out_chan.last         = out_last_r;

  // valid cells form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("queue valid bits are not a prefix");

  a_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit_vec))
    else $error("timer held by more than one cell");

  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("insert did not add one entry");

  a_expire: assert property (@(posedge clk) disable iff (!rst_n)
    load_exp |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
    else $error("expiry did not remove the head entry");

endmodule
